>>> design/cmss_pkg.sv
// Shared types and constants for the custom mode set store.
`timescale 1ns / 1ps
`default_nettype none
package cmss_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = 6;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [9:0]  refresh;
  } mode_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] width;
    logic [15:0] height;
    logic [9:0]  refresh;
    logic        builtin_hit;
    logic [4:0]  index;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [5:0]  count;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic [9:0]  out_refresh;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

endpackage
`default_nettype wire

>>> design/custom_mode_set_store.sv
// Top level of the custom mode set store: controller plus mode cell datapath.
// Each request word is first latched; then all 32 mode cells compare against the key in
// parallel and the shift-down, append or indexed read commits together with the result
// word. The next request is accepted the cycle after the commit, so no new word is taken
// while the previous one awaits its commit; a result held by rsp_stall only delays the
// commit of the following word, not its acceptance. Reset clears the entry count; cells
// need no clearing since only entries below the count are read.
`timescale 1ns / 1ps
`default_nettype none
module custom_mode_set_store (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire cmss_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output cmss_pkg::rsp_t       rsp
);
  import cmss_pkg::*;

  cmd_t cmd;

  cmss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  cmss_dp u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule
`default_nettype wire

>>> design/cmss_ctrl.sv
// Controller: sequences one word through latch and commit, owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none
module cmss_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  wire logic         rsp_stall,
  output cmss_pkg::cmd_t    cmd
);
  import cmss_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_EXEC = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;
  logic       rsp_valid_next;

  always_comb begin
    req_stall  = (state != ST_IDLE);
    cmd.load   = req_valid && (state == ST_IDLE);
    // commit only once the output register is free or being drained
    cmd.commit = (state == ST_EXEC) && (!rsp_valid || !rsp_stall);
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    rsp_valid_next = rsp_valid;
    if (cmd.commit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid)
    else $error("committed word not presented");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.commit && rsp_valid && rsp_stall))
    else $error("commit over a stalled result");
  a_load_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_EXEC) && req_stall)
    else $error("accepted word not held for execution");

endmodule
`default_nettype wire

>>> design/cmss_dp.sv
// Datapath: row of mode cells with compare, shift-down and append, plus result register.
`timescale 1ns / 1ps
`default_nettype none
module cmss_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cmss_pkg::cmd_t  cmd,
  input  wire cmss_pkg::req_t  req,
  output cmss_pkg::rsp_t       rsp
);
  import cmss_pkg::*;

  req_t                   req_q;
  mode_t                  key;
  mode_t                  entries [MAX_ENTRIES];
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] first;
  logic [MAX_ENTRIES-1:0] tail;
  logic                   hit;
  logic                   key_nz;
  logic                   full;
  logic                   add_wr;
  logic                   rem;
  logic                   ok_next;
  mode_t                  rd;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  assign key = '{width: req_q.width, height: req_q.height, refresh: req_q.refresh};

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cmp
    assign match[i] = (CNT_W'(i) < count) && (entries[i] == key);
  end

  // lowest set bit, then every cell from it upward
  assign first  = match & (~match + 1'b1);
  assign tail   = ~(first - 1'b1);
  assign hit    = |match;
  assign key_nz = (key.width != '0) && (key.height != '0) && (key.refresh != '0);
  assign full   = (count >= CNT_W'(MAX_ENTRIES));

  always_comb begin
    ok_next    = 1'b0;
    add_wr     = 1'b0;
    rem        = 1'b0;
    rd         = '0;
    count_next = count;
    unique case (req_q.func)
      FUNC_ADD: begin
        if (key_nz) begin
          if (req_q.builtin_hit || hit) begin
            ok_next = 1'b1;
          end else if (!full) begin
            ok_next    = 1'b1;
            add_wr     = 1'b1;
            count_next = count + 1'b1;
          end
        end
      end
      FUNC_REMOVE: begin
        if (hit) begin
          ok_next    = 1'b1;
          rem        = 1'b1;
          count_next = count - 1'b1;
        end
      end
      FUNC_READ: begin
        if (CNT_W'(req_q.index) < count) begin
          ok_next = 1'b1;
          rd      = entries[req_q.index[IDX_W-1:0]];
        end
      end
      default: ok_next = 1'b0;
    endcase
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i < MAX_ENTRIES - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (cmd.commit && rem && tail[i]) begin
          entries[i] <= entries[i+1];
        end else if (cmd.commit && add_wr && count[IDX_W-1:0] == IDX_W'(i)) begin
          entries[i] <= key;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (cmd.commit && add_wr && count[IDX_W-1:0] == IDX_W'(i)) begin
          entries[i] <= key;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.ok          <= ok_next;
      rsp.count       <= count_next;
      rsp.out_width   <= rd.width;
      rsp.out_height  <= rd.height;
      rsp.out_refresh <= rd.refresh;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above capacity");
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(count))
    else $error("entry count moved without a commit");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (count == $past(count_next)) &&
                   (count == $past(count) || count == $past(count) + 1'b1 ||
                    count + 1'b1 == $past(count)))
    else $error("entry count stepped by more than one");
  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp.count == count)
    else $error("result count differs from stored count");

endmodule
`default_nettype wire
